FILE: hdl/yptr_pkg.sv
// Constants, types and widths shared by the palette to RGB converter.
package yptr_pkg;

   localparam int FRAC_BITS = 16;

   localparam int HUE_W     = 5;
   localparam int CHROMA_W  = 3;
   localparam int LUMA_W    = 5;
   localparam int HUES      = 1 << HUE_W;
   localparam int LUMAS     = 1 << LUMA_W;
   localparam int CHROMAS   = 1 << CHROMA_W;
   localparam int BLACK_HUE = 24;
   localparam int STAGES    = 6;

   localparam int N_W       = 12;
   localparam int CMP_W     = 13;
   localparam int LUMA_STEP = 200;
   localparam int LUMA_DEN  = 20;
   localparam int CHROMA_DEN = 5;
   localparam int Z_DEN     = 4000;

   localparam int ZQ_W   = FRAC_BITS;
   localparam int YQ_W   = FRAC_BITS + 1;
   localparam int CQ_W   = FRAC_BITS + 1;
   localparam int INV_W  = FRAC_BITS + 4;
   localparam int A_W    = FRAC_BITS + 2;
   localparam int P_W    = FRAC_BITS + 3;
   localparam int K_W    = FRAC_BITS + 6;
   localparam int D_W    = FRAC_BITS + 2;
   localparam int S_W    = FRAC_BITS + 5;
   localparam int V_W    = FRAC_BITS + 5;
   localparam int GAIN_W = FRAC_BITS;

   localparam int M1_W = A_W + CQ_W + 1;
   localparam int M2_W = P_W + INV_W + 1;
   localparam int M3_W = D_W + K_W;
   localparam int M4_W = S_W + GAIN_W + 1;

   localparam logic [GAIN_W-1:0] GAIN =
      GAIN_W'(((64'd23 << FRAC_BITS) + 64'd12) / 64'd25);

   localparam logic signed [A_W-1:0] A_ONE = A_W'(1) << FRAC_BITS;
   localparam logic signed [V_W-1:0] V_ONE = V_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic [2:0] r;
      logic [2:0] g;
      logic [2:0] b;
   } wheel_type;

   localparam wheel_type WHEEL [HUES] = '{
      9'o400, 9'o410, 9'o420, 9'o430, 9'o440, 9'o340, 9'o240, 9'o140,
      9'o040, 9'o041, 9'o042, 9'o043, 9'o044, 9'o034, 9'o024, 9'o014,
      9'o004, 9'o104, 9'o204, 9'o304, 9'o404, 9'o403, 9'o402, 9'o401,
      9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000
   };

endpackage

FILE: hdl/ych_palette_to_rgb.sv
// Pipelined palette entry to RGB converter.
//
// Usage:
//   req channel: one palette entry per transaction, tdata[7:0] is the
//   saturation/hue byte and tdata[15:8] the luma byte.
//   rsp channel: one color per transaction, tdata[7:0] red, [15:8] green,
//   [23:16] blue, [24] opaque flag, [31:25] zero.
//   One transaction can be accepted every cycle while rsp is not
//   stalled. The rate is set by the six-stage multiply pipeline: table
//   lookup, chroma times luma, reciprocal scaling and channel offsets,
//   chroma per channel plus luma, gain, clamp to byte.
//   Each stage holds while its successor is full and stalled, so a stall
//   on rsp fills bubbles first and then drops req_tready; nothing is lost
//   or repeated. Synchronous reset empties the pipeline.
//   There is no state between entries and no configuration.
module ych_palette_to_rgb (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // sat_hue_byte, luma_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // red, green, blue, is_opaque, zero fill
);

   localparam int F = yptr_pkg::FRAC_BITS;

   logic [yptr_pkg::N_W-1:0]   n_tab    [yptr_pkg::HUES];
   logic [yptr_pkg::ZQ_W-1:0]  zq_tab   [yptr_pkg::HUES];
   logic [yptr_pkg::INV_W-1:0] invz_tab [yptr_pkg::HUES];
   logic [yptr_pkg::INV_W-1:0] inv1_tab [yptr_pkg::HUES];
   logic [yptr_pkg::YQ_W-1:0]  yq_tab   [yptr_pkg::LUMAS];
   logic [yptr_pkg::CQ_W-1:0]  cq_tab   [yptr_pkg::CHROMAS];

   for (genvar i = 0; i < yptr_pkg::HUES; i++) begin : g_hue
      localparam longint NV = 299 * longint'(yptr_pkg::WHEEL[i].r)
                            + 587 * longint'(yptr_pkg::WHEEL[i].g)
                            + 114 * longint'(yptr_pkg::WHEEL[i].b);
      localparam longint NZ = (NV == 0) ? 1 : NV;
      localparam longint NB = yptr_pkg::Z_DEN - NV;
      localparam longint ZQ = ((NV << F) + yptr_pkg::Z_DEN / 2) / yptr_pkg::Z_DEN;
      localparam longint IZ = ((longint'(yptr_pkg::Z_DEN) << F) + NZ / 2) / NZ;
      localparam longint I1 = ((longint'(yptr_pkg::Z_DEN) << F) + NB / 2) / NB;
      assign n_tab[i]    = NV[yptr_pkg::N_W-1:0];
      assign zq_tab[i]   = ZQ[yptr_pkg::ZQ_W-1:0];
      assign invz_tab[i] = IZ[yptr_pkg::INV_W-1:0];
      assign inv1_tab[i] = I1[yptr_pkg::INV_W-1:0];
   end

   for (genvar i = 0; i < yptr_pkg::LUMAS; i++) begin : g_luma
      localparam longint YQ =
         ((longint'(i) << F) + yptr_pkg::LUMA_DEN / 2) / yptr_pkg::LUMA_DEN;
      assign yq_tab[i] = YQ[yptr_pkg::YQ_W-1:0];
   end

   for (genvar i = 0; i < yptr_pkg::CHROMAS; i++) begin : g_chroma
      localparam longint CQ =
         ((longint'(i) << F) + yptr_pkg::CHROMA_DEN / 2) / yptr_pkg::CHROMA_DEN;
      assign cq_tab[i] = CQ[yptr_pkg::CQ_W-1:0];
   end

   // handshake
   logic [yptr_pkg::STAGES:1]   vld_ff;
   logic [yptr_pkg::STAGES:1]   vld_in;
   logic [yptr_pkg::STAGES+1:1] en;

   // stage 1
   yptr_pkg::wheel_type                s1_base_ff, s1_base_in;
   logic [yptr_pkg::ZQ_W-1:0]          s1_zq_ff, s1_zq_in;
   logic [yptr_pkg::YQ_W-1:0]          s1_yq_ff, s1_yq_in;
   logic [yptr_pkg::CQ_W-1:0]          s1_cq_ff, s1_cq_in;
   logic signed [yptr_pkg::A_W-1:0]    s1_a_ff, s1_a_in;
   logic [yptr_pkg::INV_W-1:0]         s1_inv_ff, s1_inv_in;
   logic                               s1_opq_ff, s1_opq_in;

   // stage 2
   yptr_pkg::wheel_type                s2_base_ff;
   logic [yptr_pkg::ZQ_W-1:0]          s2_zq_ff;
   logic [yptr_pkg::YQ_W-1:0]          s2_yq_ff;
   logic signed [yptr_pkg::P_W-1:0]    s2_p_ff, s2_p_in;
   logic [yptr_pkg::INV_W-1:0]         s2_inv_ff;
   logic                               s2_opq_ff;

   // stage 3
   logic signed [yptr_pkg::K_W-1:0]    s3_k_ff, s3_k_in;
   logic signed [yptr_pkg::D_W-1:0]    s3_d_ff [3];
   logic signed [yptr_pkg::D_W-1:0]    s3_d_in [3];
   logic [yptr_pkg::YQ_W-1:0]          s3_yq_ff;
   logic                               s3_opq_ff;

   // stage 4
   logic signed [yptr_pkg::S_W-1:0]    s4_s_ff [3];
   logic signed [yptr_pkg::S_W-1:0]    s4_s_in [3];
   logic                               s4_opq_ff;

   // stage 5
   logic signed [yptr_pkg::V_W-1:0]    s5_v_ff [3];
   logic signed [yptr_pkg::V_W-1:0]    s5_v_in [3];
   logic                               s5_opq_ff;

   // stage 6
   logic [7:0]                         s6_byte_ff [3];
   logic [7:0]                         s6_byte_in [3];
   logic                               s6_opq_ff;

   logic [yptr_pkg::HUE_W-1:0]         hue;
   logic [yptr_pkg::CHROMA_W-1:0]      chroma;
   logic [yptr_pkg::LUMA_W-1:0]        luma;
   logic [yptr_pkg::N_W-1:0]           n_sel;
   logic                               dark;

   logic signed [yptr_pkg::M1_W-1:0]   m1;
   logic signed [yptr_pkg::M2_W-1:0]   m2;
   logic signed [yptr_pkg::M3_W-1:0]   m3 [3];
   logic signed [yptr_pkg::S_W-1:0]    r3 [3];
   logic signed [yptr_pkg::M4_W-1:0]   m4 [3];
   logic [F+7:0]                       scaled [3];
   logic [2:0]                         quarter [3];

   always_comb begin
      en[yptr_pkg::STAGES+1] = rsp_tready;
      for (int i = yptr_pkg::STAGES; i >= 1; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[1] = req_tvalid;
      for (int i = 2; i <= yptr_pkg::STAGES; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   assign req_tready = en[1];
   assign rsp_tvalid = vld_ff[yptr_pkg::STAGES];
   assign rsp_tdata  = {7'd0, s6_opq_ff, s6_byte_ff[2], s6_byte_ff[1], s6_byte_ff[0]};

   // lookup and branch select
   always_comb begin
      hue    = req_tdata[yptr_pkg::HUE_W-1:0];
      chroma = req_tdata[7:yptr_pkg::HUE_W];
      luma   = req_tdata[8 +: yptr_pkg::LUMA_W];
      n_sel  = n_tab[hue];
      dark   = (yptr_pkg::CMP_W'(luma) * yptr_pkg::CMP_W'(yptr_pkg::LUMA_STEP)
                < yptr_pkg::CMP_W'(n_sel)) && (n_sel != '0);
      s1_base_in = yptr_pkg::WHEEL[hue];
      s1_zq_in   = zq_tab[hue];
      s1_yq_in   = yq_tab[luma];
      s1_cq_in   = cq_tab[chroma];
      s1_a_in    = dark ? $signed({1'b0, s1_yq_in})
                        : yptr_pkg::A_ONE - $signed({1'b0, s1_yq_in});
      s1_inv_in  = dark ? invz_tab[hue] : inv1_tab[hue];
      s1_opq_in  = (hue < yptr_pkg::HUE_W'(yptr_pkg::BLACK_HUE));
   end

   // chroma times luma term
   always_comb begin
      m1 = yptr_pkg::M1_W'(s1_a_ff) * yptr_pkg::M1_W'($signed({1'b0, s1_cq_ff}));
      m1 = m1 + (yptr_pkg::M1_W'(1) <<< (F - 1));
      m1 = m1 >>> F;
      s2_p_in = m1[yptr_pkg::P_W-1:0];
   end

   // reciprocal scaling and channel offsets
   always_comb begin
      m2 = yptr_pkg::M2_W'(s2_p_ff) * yptr_pkg::M2_W'($signed({1'b0, s2_inv_ff}));
      m2 = m2 + (yptr_pkg::M2_W'(1) <<< (F - 1));
      m2 = m2 >>> F;
      s3_k_in = m2[yptr_pkg::K_W-1:0];
      quarter[0] = s2_base_ff.r;
      quarter[1] = s2_base_ff.g;
      quarter[2] = s2_base_ff.b;
      for (int c = 0; c < 3; c++) begin
         s3_d_in[c] = $signed(yptr_pkg::D_W'({quarter[c], {(F - 2){1'b0}}}))
                    - $signed(yptr_pkg::D_W'(s2_zq_ff));
      end
   end

   // chroma applied per channel plus luma
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         m3[c] = yptr_pkg::M3_W'(s3_d_ff[c]) * yptr_pkg::M3_W'(s3_k_ff);
         m3[c] = m3[c] + (yptr_pkg::M3_W'(1) <<< (F - 1));
         m3[c] = m3[c] >>> F;
         r3[c] = m3[c][yptr_pkg::S_W-1:0];
         s4_s_in[c] = r3[c] + yptr_pkg::S_W'($signed({1'b0, s3_yq_ff}));
      end
   end

   // output gain
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         m4[c] = yptr_pkg::M4_W'(s4_s_ff[c])
               * yptr_pkg::M4_W'($signed({1'b0, yptr_pkg::GAIN}));
         m4[c] = m4[c] + (yptr_pkg::M4_W'(1) <<< (F - 1));
         m4[c] = m4[c] >>> F;
         s5_v_in[c] = m4[c][yptr_pkg::V_W-1:0];
      end
   end

   // clamp and scale to byte
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         scaled[c] = {s5_v_ff[c][F-1:0], 8'd0} - (F + 8)'(s5_v_ff[c][F-1:0]);
         if (s5_v_ff[c] <= 0) begin
            s6_byte_in[c] = 8'd0;
         end else if (s5_v_ff[c] >= yptr_pkg::V_ONE) begin
            s6_byte_in[c] = 8'd255;
         end else begin
            s6_byte_in[c] = scaled[c][F+7:F];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 1; i <= yptr_pkg::STAGES; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_base_ff <= s1_base_in;
         s1_zq_ff   <= s1_zq_in;
         s1_yq_ff   <= s1_yq_in;
         s1_cq_ff   <= s1_cq_in;
         s1_a_ff    <= s1_a_in;
         s1_inv_ff  <= s1_inv_in;
         s1_opq_ff  <= s1_opq_in;
      end
      if (en[2]) begin
         s2_base_ff <= s1_base_ff;
         s2_zq_ff   <= s1_zq_ff;
         s2_yq_ff   <= s1_yq_ff;
         s2_p_ff    <= s2_p_in;
         s2_inv_ff  <= s1_inv_ff;
         s2_opq_ff  <= s1_opq_ff;
      end
      if (en[3]) begin
         s3_k_ff   <= s3_k_in;
         s3_d_ff   <= s3_d_in;
         s3_yq_ff  <= s2_yq_ff;
         s3_opq_ff <= s2_opq_ff;
      end
      if (en[4]) begin
         s4_s_ff   <= s4_s_in;
         s4_opq_ff <= s3_opq_ff;
      end
      if (en[5]) begin
         s5_v_ff   <= s5_v_in;
         s5_opq_ff <= s4_opq_ff;
      end
      if (en[6]) begin
         s6_byte_ff <= s6_byte_in;
         s6_opq_ff  <= s5_opq_ff;
      end
   end

`ifndef ASSERT_OFF
   a_black_is_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[24] |->
         rsp_tdata[7:0] == rsp_tdata[15:8] && rsp_tdata[15:8] == rsp_tdata[23:16])
      else $error("transparent color is not gray");

   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      !(&vld_ff) |-> req_tready)
      else $error("pipeline has a bubble but refuses input");

   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] && !en[3] |=> vld_ff[3] && $stable(s3_k_ff))
      else $error("stalled stage dropped its transaction");
`endif

endmodule
